@@ hdl/rbpa_pkg.sv @@
`default_nettype none

package rbpa_pkg;

    // Page field width of the request and response items, and the mask size and pick width of lowest_set
    localparam int PAGE_W    = 10;
    localparam int MAX_PAGES = 64;
    localparam int PICK_W    = 6;

    typedef logic [PAGE_W-1:0] t_page;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_UPDATE,
        S_RESP
    } t_state;

    // Return the position of the lowest set bit; all zero gives the top position
    function automatic logic [PICK_W-1:0] lowest_set(input logic [MAX_PAGES-1:0] v);
        logic [PICK_W-1:0] res;
        res = PICK_W'(MAX_PAGES - 1);
        for (int i = MAX_PAGES - 2; i >= 0; i--) begin
            if (v[i]) begin
                res = PICK_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hdl/rbpa_req_if.sv @@
`default_nettype none

interface rbpa_req_if import rbpa_pkg::*; ();
    logic  valid;
    logic  ready;
    t_op   op;
    t_page page_number;

    modport source (output valid, output op, output page_number, input ready);
    modport sink   (input valid, input op, input page_number, output ready);
endinterface

`default_nettype wire

@@ hdl/rbpa_rsp_if.sv @@
`default_nettype none

interface rbpa_rsp_if import rbpa_pkg::*; ();
    logic    valid;
    logic    ready;
    t_status status;
    t_page   granted_page;

    modport source (output valid, output status, output granted_page, input ready);
    modport sink   (input valid, input status, input granted_page, output ready);
endinterface

`default_nettype wire

@@ hdl/rbpa_mask_ram.sv @@
`default_nettype none

module rbpa_mask_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one free mask
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one free mask, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/region_bitmap_page_allocator_unit.sv @@
// Flow: an alloc walks the regions from region 0 to the first held region with free pages,
//   then reads and updates its mask and responds; opening a fresh region or reporting no
//   space needs the full scan. A free walks to its region and answers without a mask read when it is idle.
// Throughput: one item at a time; the region scan walks one region per cycle and the mask
//   memory serves at most one read and one write per item.
// Reset: flags and control clear synchronously; masks are written on activation, before any read.
`default_nettype none

module region_bitmap_page_allocator_unit import rbpa_pkg::*; #(
    parameter int REGION_COUNT     = 16,
    parameter int PAGES_PER_REGION = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbpa_req_if.sink  i_req,
    rbpa_rsp_if.source o_rsp
);

    localparam int RIW  = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam int CNTW = $clog2(REGION_COUNT + 1);
    localparam int IW   = $clog2(PAGES_PER_REGION);
    localparam int POOL = REGION_COUNT * PAGES_PER_REGION;
    localparam int BW   = $clog2(POOL + 1);
    localparam int CW   = ((BW > PAGE_W) ? BW : PAGE_W) + 1;
    localparam logic [PAGES_PER_REGION-1:0] FULL        = '1;
    localparam logic [PAGES_PER_REGION-1:0] FIRST_TAKEN = {{(PAGES_PER_REGION-1){1'b1}}, 1'b0};

    t_state                    r_state, n_state;
    t_op                       r_op, n_op;
    t_page                     r_page, n_page;
    logic [CNTW-1:0]           r_idx, n_idx;
    logic [BW-1:0]             r_base, n_base;
    logic                      r_inact_valid, n_inact_valid;
    logic [RIW-1:0]            r_inact_idx, n_inact_idx;
    logic [BW-1:0]             r_inact_base, n_inact_base;
    logic [REGION_COUNT-1:0]   r_active, n_active;
    logic [REGION_COUNT-1:0]   r_nonempty, n_nonempty;
    t_status                   r_status, n_status;
    t_page                     r_grant, n_grant;
    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    t_page                     r_out_grant, n_out_grant;

    logic                        mem_we;
    logic [RIW-1:0]              mem_waddr;
    logic [PAGES_PER_REGION-1:0] mem_wdata;
    logic                        mem_re;
    logic [PAGES_PER_REGION-1:0] rd_mask;

    logic [RIW-1:0]              cur;
    logic                        at_end;
    logic [CW-1:0]               lim;
    logic                        page_hit;
    logic [CW-1:0]               offset;
    logic [IW-1:0]               page_idx;
    logic [PICK_W-1:0]           pick_full;
    logic [IW-1:0]               pick;
    logic [PAGES_PER_REGION-1:0] pick_bit;
    logic [PAGES_PER_REGION-1:0] free_bit;
    logic [PAGES_PER_REGION-1:0] alloc_mask;
    logic [PAGES_PER_REGION-1:0] freed_mask;

    rbpa_mask_ram #(
        .DEPTH (REGION_COUNT),
        .WIDTH (PAGES_PER_REGION)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (cur),
        .o_rdata (rd_mask)
    );

    // Region under the scan and its page range
    assign cur      = r_idx[RIW-1:0];
    assign at_end   = (r_idx == CNTW'(REGION_COUNT));
    assign lim      = CW'(r_base) + CW'(PAGES_PER_REGION);
    assign page_hit = (CW'(r_page) < lim);
    assign offset   = CW'(r_page) - CW'(r_base);
    assign page_idx = offset[IW-1:0];

    // Pick the lowest free page and form the updated masks
    assign pick_full  = lowest_set(MAX_PAGES'(rd_mask));
    assign pick       = pick_full[IW-1:0];
    assign pick_bit   = PAGES_PER_REGION'(1) << pick;
    assign free_bit   = PAGES_PER_REGION'(1) << page_idx;
    assign alloc_mask = rd_mask & ~pick_bit;
    assign freed_mask = rd_mask | free_bit;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_page = r_out_grant;

    // Hold state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_inact_valid <= 1'b0;
            r_active      <= '0;
            r_nonempty    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_inact_valid <= n_inact_valid;
            r_active      <= n_active;
            r_nonempty    <= n_nonempty;
            r_out_valid   <= n_out_valid;
        end
    end

    // Hold payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_page       <= n_page;
        r_base       <= n_base;
        r_inact_idx  <= n_inact_idx;
        r_inact_base <= n_inact_base;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

    // Sequence the scan, the mask read and the mask update
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_page        = r_page;
        n_idx         = r_idx;
        n_base        = r_base;
        n_inact_valid = r_inact_valid;
        n_inact_idx   = r_inact_idx;
        n_inact_base  = r_inact_base;
        n_active      = r_active;
        n_nonempty    = r_nonempty;
        n_status      = r_status;
        n_grant       = r_grant;
        n_out_valid   = r_out_valid & ~o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_grant   = r_out_grant;
        mem_we        = 1'b0;
        mem_waddr     = cur;
        mem_wdata     = alloc_mask;
        mem_re        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op          = i_req.op;
                    n_page        = i_req.page_number;
                    n_idx         = '0;
                    n_base        = '0;
                    n_inact_valid = 1'b0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_op == OP_ALLOC) begin
                    if (at_end) begin
                        if (r_inact_valid) begin
                            // Open the lowest idle region and grant its first page
                            mem_we                  = 1'b1;
                            mem_waddr               = r_inact_idx;
                            mem_wdata               = FIRST_TAKEN;
                            n_active[r_inact_idx]   = 1'b1;
                            n_nonempty[r_inact_idx] = 1'b1;
                            n_status                = ST_OK;
                            n_grant                 = PAGE_W'(r_inact_base);
                        end else begin
                            n_status = ST_NO_SPACE;
                            n_grant  = '0;
                        end
                        n_state = S_RESP;
                    end else if (r_active[cur] && r_nonempty[cur]) begin
                        n_state = S_READ;
                    end else begin
                        if (!r_active[cur] && !r_inact_valid) begin
                            n_inact_valid = 1'b1;
                            n_inact_idx   = cur;
                            n_inact_base  = r_base;
                        end
                        n_idx  = r_idx + CNTW'(1);
                        n_base = r_base + BW'(PAGES_PER_REGION);
                    end
                end else begin
                    if (at_end) begin
                        n_status = ST_BAD_FREE;
                        n_grant  = '0;
                        n_state  = S_RESP;
                    end else if (page_hit) begin
                        if (r_active[cur]) begin
                            n_state = S_READ;
                        end else begin
                            n_status = ST_BAD_FREE;
                            n_grant  = '0;
                            n_state  = S_RESP;
                        end
                    end else begin
                        n_idx  = r_idx + CNTW'(1);
                        n_base = r_base + BW'(PAGES_PER_REGION);
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (r_op == OP_ALLOC) begin
                    mem_we          = 1'b1;
                    mem_wdata       = alloc_mask;
                    n_nonempty[cur] = |alloc_mask;
                    n_status        = ST_OK;
                    n_grant         = PAGE_W'(r_base + BW'(pick));
                end else begin
                    n_grant = '0;
                    if (|(rd_mask & free_bit)) begin
                        n_status = ST_BAD_FREE;
                    end else begin
                        // Return the page; drop the region once all of it is free
                        mem_we          = 1'b1;
                        mem_wdata       = freed_mask;
                        n_nonempty[cur] = 1'b1;
                        if (freed_mask == FULL) begin
                            n_active[cur] = 1'b0;
                        end
                        n_status = ST_OK;
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_grant  = r_grant;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // An update only ever touches a held region
    a_update_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> r_active[cur])
        else $error("mask update on a region that is not held");

    // The free-page flag agrees with the stored mask
    a_alloc_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_op == OP_ALLOC) |-> (rd_mask != '0))
        else $error("region flagged as having free pages holds an empty mask");

    // The scan never runs past the pool
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= CNTW'(REGION_COUNT))
        else $error("region scan ran past the pool");

    // No space is reported only when every region is held
    a_no_space_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_op == OP_ALLOC && r_status == ST_NO_SPACE) |-> (&r_active))
        else $error("no space reported while a region is idle");

endmodule

`default_nettype wire
